>>> rtl/mrcc_pkg.sv
// Shared types, constants and the sigmoid table function for the region contrast classifier.
package mrcc_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DIFF_W    = 17;
  localparam int unsigned PROB_W    = 16;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned MEAN_Q_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CLUTTER_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CONTRAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_CONTRAST = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] CLUTTER_FLOOR_RST = -16'sd5376;
  localparam logic signed [SAMPLE_W-1:0] LOW_CONTRAST_RST  = 16'sd896;
  localparam logic signed [SAMPLE_W-1:0] HIGH_CONTRAST_RST = 16'sd1536;

  localparam logic [PROB_W-1:0] PROB_FLOOR          = 16'd32768;
  localparam logic [PROB_W-1:0] PROB_CEIL           = 16'd64881;
  localparam logic [PROB_W-1:0] PROB_LOOKALIKE_DARK = 16'd13107;
  localparam logic [PROB_W-1:0] PROB_LOOKALIKE_LOW  = 16'd22938;
  localparam logic [PROB_W-1:0] PROB_MID            = 16'd36045;

  // sigmoid center at 5.5 dB; index base is center minus half a 1/16 dB step
  localparam logic signed [DIFF_W-1:0] SIGMOID_CENTER   = 17'sd1408;
  localparam logic signed [DIFF_W-1:0] SIGMOID_IDX_BASE = 17'sd1400;

  localparam logic [31:0] EXP_STEP_Q32 = 32'd4085499269;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CLASS,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SEL_SLICK_CO,
    SEL_SLICK_CX,
    SEL_CLUTTER_CO
  } mean_sel_e;

  typedef struct packed {
    logic      acc_en;
    logic      div_start;
    mean_sel_e sel;
    logic      div_capture;
    logic      class_en;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
  } dp_stat_t;

  // elaboration-time table entry: clamp(round(2^48 / (2^32 + E_idx)))
  function automatic logic [PROB_W-1:0] sig_entry(input int unsigned idx);
    logic [95:0] prod;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [64:0] rem;
    logic [63:0] q;
    int unsigned i;
    int b;
    e = 64'h1_0000_0000;
    for (i = 0; i < idx; i++) begin
      prod = {32'd0, e} * {64'd0, EXP_STEP_Q32};
      prod = prod + (96'd1 << 31);
      e    = prod[95:32];
    end
    den = 64'h1_0000_0000 + e;
    num = (64'd1 << 48) + (den >> 1);
    rem = '0;
    q   = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    if (q < 64'(PROB_FLOOR)) q = 64'(PROB_FLOOR);
    if (q > 64'(PROB_CEIL)) q = 64'(PROB_CEIL);
    return q[PROB_W-1:0];
  endfunction

endpackage

>>> rtl/masked_region_contrast_classifier_core.sv
// Top level of the masked region contrast classifier: pixel stream in, region profile out.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata co/cross-pol, tuser mask, tlast
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata means/diffs/prob, tuser flags
//  cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_addr_i index, cfg_wdata_i value
//
// Pixels are taken one per cycle while the controller accumulates. After the last pixel of a frame intake stops
// for three mean divisions on one shared divider (start, 17 quotient steps, capture), then the
// differences, then classification and result load. With an empty class the divisions are
// skipped and intake stops only for the start and result load states. The result sits in an output register;
// intake resumes while it waits, and only the next last pixel's result waits for its slot.
// Reset clears the accumulators and loads the default thresholds.
module masked_region_contrast_classifier_core
  import mrcc_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT_BITS    = 24,
  parameter int unsigned SIGMOID_TABLE_DEPTH = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // copol_sample, crosspol_sample
  input  logic [MASK_W-1:0]      s_axis_tuser,   // mask_byte
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slick_copol_mean, slick_crosspol_mean, clutter_copol_mean, contrast_ratio,
  // dual_pol_difference, probability, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [OUT_USER_W-1:0]  m_axis_tuser,   // look_alike, profile_valid
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [SAMPLE_W-1:0]    cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [SAMPLE_W-1:0] slick_copol_mean;
  logic signed [SAMPLE_W-1:0] slick_crosspol_mean;
  logic signed [SAMPLE_W-1:0] clutter_copol_mean;
  logic signed [DIFF_W-1:0]   contrast_ratio;
  logic signed [DIFF_W-1:0]   dual_pol_difference;
  logic                       look_alike;
  logic [PROB_W-1:0]          probability;
  logic                       profile_valid;

  assign cfg_ready_o = 1'b1;

  mrcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mrcc_datapath #(
    .PIXEL_COUNT_BITS   (PIXEL_COUNT_BITS),
    .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .copol_i              (s_axis_tdata[15:0]),
    .crosspol_i           (s_axis_tdata[31:16]),
    .mask_i               (s_axis_tuser),
    .slick_copol_mean_o   (slick_copol_mean),
    .slick_crosspol_mean_o(slick_crosspol_mean),
    .clutter_copol_mean_o (clutter_copol_mean),
    .contrast_ratio_o     (contrast_ratio),
    .dual_pol_difference_o(dual_pol_difference),
    .look_alike_o         (look_alike),
    .probability_o        (probability),
    .profile_valid_o      (profile_valid)
  );

  assign m_axis_tdata = {6'd0, probability, dual_pol_difference, contrast_ratio,
                         clutter_copol_mean, slick_crosspol_mean, slick_copol_mean};
  assign m_axis_tuser = {profile_valid, look_alike};

endmodule

>>> rtl/mrcc_div.sv
// Shared restoring divider, one quotient bit per cycle while busy, quotient known to fit QUOT_W bits.
module mrcc_div #(
  parameter int unsigned NUM_W  = 41,
  parameter int unsigned DEN_W  = 26,
  parameter int unsigned QUOT_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [QUOT_W-1:0] low_q, low_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = DEN_W'(num_i[NUM_W-1:QUOT_W]);
      low_d  = num_i[QUOT_W-1:0];
      den_d  = den_i;
      step_d = STEP_W'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_d  = {low_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      busy_d = (step_q != STEP_W'(1));
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/mrcc_datapath.sv
// Datapath: class accumulators, config registers, mean division, thresholds and result register.
module mrcc_datapath
  import mrcc_pkg::*;
#(
  parameter int unsigned PIXEL_COUNT_BITS    = 24,
  parameter int unsigned SIGMOID_TABLE_DEPTH = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_stat_t                    stat_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic signed [SAMPLE_W-1:0]  cfg_wdata_i,
  input  logic signed [SAMPLE_W-1:0]  copol_i,
  input  logic signed [SAMPLE_W-1:0]  crosspol_i,
  input  logic [MASK_W-1:0]           mask_i,
  output logic signed [SAMPLE_W-1:0]  slick_copol_mean_o,
  output logic signed [SAMPLE_W-1:0]  slick_crosspol_mean_o,
  output logic signed [SAMPLE_W-1:0]  clutter_copol_mean_o,
  output logic signed [DIFF_W-1:0]    contrast_ratio_o,
  output logic signed [DIFF_W-1:0]    dual_pol_difference_o,
  output logic                        look_alike_o,
  output logic [PROB_W-1:0]           probability_o,
  output logic                        profile_valid_o
);

  localparam int unsigned CNT_W     = PIXEL_COUNT_BITS + 1;
  localparam int unsigned SUM_W     = PIXEL_COUNT_BITS + SAMPLE_W;
  localparam int unsigned NUM_W     = SUM_W + 1;
  localparam int unsigned DEN_W     = CNT_W + 1;
  localparam int unsigned TAB_IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned SIG_OFF_W = DIFF_W - 4;

  // config registers
  logic signed [SAMPLE_W-1:0] floor_q, low_lim_q, high_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q    <= CLUTTER_FLOOR_RST;
      low_lim_q  <= LOW_CONTRAST_RST;
      high_lim_q <= HIGH_CONTRAST_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CLUTTER_FLOOR: floor_q    <= cfg_wdata_i;
        REG_LOW_CONTRAST:  low_lim_q  <= cfg_wdata_i;
        REG_HIGH_CONTRAST: high_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // accumulators
  logic signed [SUM_W-1:0] s_co_q, s_co_d, s_cx_q, s_cx_d, c_co_q, c_co_d;
  logic [CNT_W-1:0]        s_cnt_q, s_cnt_d, c_cnt_q, c_cnt_d;
  logic                    is_slick;

  assign is_slick = |mask_i;

  always_comb begin
    s_co_d  = s_co_q;
    s_cx_d  = s_cx_q;
    c_co_d  = c_co_q;
    s_cnt_d = s_cnt_q;
    c_cnt_d = c_cnt_q;
    if (cmd_i.load_out) begin
      s_co_d  = '0;
      s_cx_d  = '0;
      c_co_d  = '0;
      s_cnt_d = '0;
      c_cnt_d = '0;
    end else if (cmd_i.acc_en) begin
      // counts saturate at 2^PIXEL_COUNT_BITS (top bit set)
      if (is_slick) begin
        if (!s_cnt_q[CNT_W-1]) begin
          s_co_d  = s_co_q + SUM_W'(copol_i);
          s_cx_d  = s_cx_q + SUM_W'(crosspol_i);
          s_cnt_d = s_cnt_q + CNT_W'(1);
        end
      end else if (!c_cnt_q[CNT_W-1]) begin
        c_co_d  = c_co_q + SUM_W'(copol_i);
        c_cnt_d = c_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_co_q  <= '0;
      s_cx_q  <= '0;
      c_co_q  <= '0;
      s_cnt_q <= '0;
      c_cnt_q <= '0;
    end else begin
      s_co_q  <= s_co_d;
      s_cx_q  <= s_cx_d;
      c_co_q  <= c_co_d;
      s_cnt_q <= s_cnt_d;
      c_cnt_q <= c_cnt_d;
    end
  end

  // divider operands: |s|/c rounded half away from zero = (2|s| + c) / 2c
  logic signed [SUM_W-1:0] sel_sum;
  logic [CNT_W-1:0]        sel_cnt;
  logic [NUM_W-1:0]        two_sum;
  logic [NUM_W-1:0]        cnt_ext;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic [MEAN_Q_W-1:0]     quot;
  logic                    neg_q;

  always_comb begin
    case (cmd_i.sel)
      SEL_SLICK_CO: begin
        sel_sum = s_co_q;
        sel_cnt = s_cnt_q;
      end
      SEL_SLICK_CX: begin
        sel_sum = s_cx_q;
        sel_cnt = s_cnt_q;
      end
      SEL_CLUTTER_CO: begin
        sel_sum = c_co_q;
        sel_cnt = c_cnt_q;
      end
      default: begin
        sel_sum = c_co_q;
        sel_cnt = c_cnt_q;
      end
    endcase
  end

  assign two_sum = {sel_sum, 1'b0};
  assign cnt_ext = NUM_W'(sel_cnt);
  assign div_num = sel_sum[SUM_W-1] ? (cnt_ext - two_sum) : (two_sum + cnt_ext);
  assign div_den = {sel_cnt, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) neg_q <= sel_sum[SUM_W-1];
  end

  mrcc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUOT_W(MEAN_Q_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot)
  );

  // means
  logic [MEAN_Q_W-1:0]        mean_full;
  logic signed [SAMPLE_W-1:0] sm_q, sx_q, cm_q;

  assign mean_full = neg_q ? (MEAN_Q_W'(0) - quot) : quot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_capture) begin
      case (cmd_i.sel)
        SEL_SLICK_CO:   sm_q <= mean_full[SAMPLE_W-1:0];
        SEL_SLICK_CX:   sx_q <= mean_full[SAMPLE_W-1:0];
        SEL_CLUTTER_CO: cm_q <= mean_full[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // differences
  logic signed [DIFF_W-1:0] contrast_q, dpd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.class_en) begin
      contrast_q <= DIFF_W'(cm_q) - DIFF_W'(sm_q);
      dpd_q      <= DIFF_W'(sm_q) - DIFF_W'(sx_q);
    end
  end

  // sigmoid table
  logic [PROB_W-1:0] sig_tab [SIGMOID_TABLE_DEPTH];

  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [PROB_W-1:0] Entry = sig_entry(g);
    assign sig_tab[g] = Entry;
  end

  // classification
  logic signed [DIFF_W-1:0] sig_off;
  logic [SIG_OFF_W-1:0]     sig_idx;
  logic [PROB_W-1:0]        sig_prob;
  logic                     look;
  logic [PROB_W-1:0]        prob;

  assign sig_off = contrast_q - SIGMOID_IDX_BASE;
  assign sig_idx = sig_off[DIFF_W-1:4];

  always_comb begin
    if (contrast_q < SIGMOID_CENTER) begin
      sig_prob = PROB_FLOOR;
    end else if (sig_idx >= SIG_OFF_W'(SIGMOID_TABLE_DEPTH)) begin
      sig_prob = PROB_CEIL;
    end else begin
      sig_prob = sig_tab[sig_idx[TAB_IDX_W-1:0]];
    end
  end

  always_comb begin
    look = 1'b0;
    prob = PROB_MID;
    if (cm_q < floor_q) begin
      look = 1'b1;
      prob = PROB_LOOKALIKE_DARK;
    end else if (contrast_q < DIFF_W'(low_lim_q)) begin
      look = 1'b1;
      prob = PROB_LOOKALIKE_LOW;
    end else if (contrast_q >= DIFF_W'(high_lim_q)) begin
      prob = sig_prob;
    end
  end

  // result register
  logic empty;

  assign empty = (s_cnt_q == '0) || (c_cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (empty) begin
        slick_copol_mean_o    <= '0;
        slick_crosspol_mean_o <= '0;
        clutter_copol_mean_o  <= '0;
        contrast_ratio_o      <= '0;
        dual_pol_difference_o <= '0;
        look_alike_o          <= 1'b0;
        probability_o         <= '0;
        profile_valid_o       <= 1'b0;
      end else begin
        slick_copol_mean_o    <= sm_q;
        slick_crosspol_mean_o <= sx_q;
        clutter_copol_mean_o  <= cm_q;
        contrast_ratio_o      <= contrast_q;
        dual_pol_difference_o <= dpd_q;
        look_alike_o          <= look;
        probability_o         <= prob;
        profile_valid_o       <= 1'b1;
      end
    end
  end

  assign stat_o.empty    = empty;
  assign stat_o.div_done = div_done;

endmodule

>>> rtl/mrcc_ctrl.sv
// Controller: pixel intake, division sequencing and result handshake.
module mrcc_ctrl
  import mrcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  mean_sel_e   sel_q, sel_d;
  logic        out_valid_q, out_valid_d;
  logic        in_take;
  logic        slot_free;

  assign in_take   = in_valid_i && (state_q == ST_ACCUM);
  assign slot_free = !out_valid_q || out_ready_i;

  function automatic mean_sel_e next_sel(input mean_sel_e s);
    case (s)
      SEL_SLICK_CO: return SEL_SLICK_CX;
      SEL_SLICK_CX: return SEL_CLUTTER_CO;
      default:      return SEL_SLICK_CO;
    endcase
  endfunction

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_ACCUM: begin
        sel_d = SEL_SLICK_CO;
        if (in_take && in_last_i) state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_d = stat_i.empty ? ST_EMIT : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          if (sel_q == SEL_CLUTTER_CO) begin
            state_d = ST_CLASS;
          end else begin
            sel_d   = next_sel(sel_q);
            state_d = ST_DIV_START;
          end
        end
      end
      ST_CLASS: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.sel         = sel_q;
    in_ready_o        = 1'b0;
    out_valid_d       = out_valid_q && !out_ready_i;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_take;
      end
      ST_DIV_START: cmd_o.div_start = !stat_i.empty;
      ST_DIV_WAIT:  cmd_o.div_capture = stat_i.div_done;
      ST_CLASS:     cmd_o.class_en = 1'b1;
      ST_EMIT: begin
        cmd_o.load_out = slot_free;
        if (slot_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      sel_q       <= SEL_SLICK_CO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
